/* hdl/tiered_budget_placement_defines.svh */
// ----------------------------------------------------------------------------
// Tiered budget placement: assertion macros
// Shared assertion forms for the checker of the placement block.
// ----------------------------------------------------------------------------
`ifndef TIERED_BUDGET_PLACEMENT_DEFINES_SVH
`define TIERED_BUDGET_PLACEMENT_DEFINES_SVH

// Assertion that is checked only outside reset.
`define TBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Assertion that is also checked while reset is applied.
`define TBP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* hdl/tbp_pkg.sv */
// ----------------------------------------------------------------------------
// Tiered budget placement package
// Shared types, codes and default sizes of the placement block.
// ----------------------------------------------------------------------------
package tbp_pkg;

    // Default table depth and byte-size width.
    localparam int DEF_MAX_ENTRIES = 64;
    localparam int DEF_SIZE_BITS   = 40;
    // Staging usage is kept this many bits wider than a size.
    localparam int STAGING_EXTRA   = 6;

    typedef enum logic [1:0] {
        TIER_FAST    = 2'd0,
        TIER_STAGING = 2'd1,
        TIER_SLOW    = 2'd2,
        TIER_NONE    = 2'd3
    } t_tier;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVER = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic {
        CFG_FAST_BUDGET   = 1'b0,
        CFG_STAGING_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ALU_FAST  = 1'b0,
        ALU_STAGE = 1'b1
    } t_alu_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FAST_CHK,
        S_WALK,
        S_RETRY,
        S_STAGE_CHK,
        S_STORE,
        S_EMIT
    } t_state;

endpackage

/* hdl/tbp_req_if.sv */
// ----------------------------------------------------------------------------
// Placement request channel
// Valid/ready channel that carries one shard request word.
// ----------------------------------------------------------------------------
interface tbp_req_if
    import tbp_pkg::*;
#(
    parameter int SIZE_BITS = DEF_SIZE_BITS
);
    logic                 valid;
    logic                 ready;
    logic [SIZE_BITS-1:0] shard_size;
    logic                 prefer_fast;

    modport source (output valid, output shard_size, output prefer_fast, input ready);
    modport sink   (input valid, input shard_size, input prefer_fast, output ready);
endinterface

/* hdl/tbp_rsp_if.sv */
// ----------------------------------------------------------------------------
// Placement result channel
// Valid/ready channel that carries one placement result word.
// ----------------------------------------------------------------------------
interface tbp_rsp_if
    import tbp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int SIZE_BITS   = DEF_SIZE_BITS
);
    localparam int STB = SIZE_BITS + STAGING_EXTRA;
    localparam int EW  = $clog2(MAX_ENTRIES + 1);

    logic           valid;
    logic           ready;
    t_tier          placed_tier;
    t_status        status;
    logic [SIZE_BITS-1:0] fast_used;
    logic [STB-1:0] staging_used;
    logic [EW-1:0]  evicted_count;

    modport source (output valid, output placed_tier, output status, output fast_used,
                    output staging_used, output evicted_count, input ready);
    modport sink   (input valid, input placed_tier, input status, input fast_used,
                    input staging_used, input evicted_count, output ready);
endinterface

/* hdl/tbp_addcmp.sv */
// ----------------------------------------------------------------------------
// Shared add-and-compare unit
// Forms usage plus shard size and tests it against the selected limit.
// ----------------------------------------------------------------------------
module tbp_addcmp
    import tbp_pkg::*;
#(
    parameter int SIZE_BITS = DEF_SIZE_BITS
) (
    input  t_alu_sel                         i_sel,
    input  logic [SIZE_BITS-1:0]             i_fast,
    input  logic [SIZE_BITS+STAGING_EXTRA-1:0] i_staging,
    input  logic [SIZE_BITS-1:0]             i_need,
    input  logic [SIZE_BITS-1:0]             i_budget,
    input  logic [SIZE_BITS-1:0]             i_limit,
    output logic [SIZE_BITS+STAGING_EXTRA:0] o_sum,
    output logic                             o_le
);
    localparam int STB = SIZE_BITS + STAGING_EXTRA;

    logic [STB-1:0]   a;
    logic [SIZE_BITS-1:0] lim;

    always_comb begin
        case (i_sel)
            ALU_FAST: begin
                a   = STB'(i_fast);
                lim = i_budget;
            end
            default: begin
                a   = i_staging;
                lim = i_limit;
            end
        endcase
        o_sum = {1'b0, a} + (STB+1)'(i_need);
        o_le  = o_sum <= (STB+1)'(lim);
    end
endmodule

/* hdl/tbp_table.sv */
// ----------------------------------------------------------------------------
// Shard table memory
// One write port and one registered read port; each word is a fast flag
// above the entry size.
// ----------------------------------------------------------------------------
module tbp_table
    import tbp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int SIZE_BITS   = DEF_SIZE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] i_waddr,
    input  logic [SIZE_BITS:0]                     i_wdata,
    input  logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] i_raddr,
    output logic [SIZE_BITS:0]                     o_rdata
);
    logic [SIZE_BITS:0] mem [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

/* hdl/tbp_seq.sv */
// ----------------------------------------------------------------------------
// Placement sequencer
// Runs the checks through the shared unit, walks the table for eviction,
// stores the entry and holds the result word.
// ----------------------------------------------------------------------------
module tbp_seq
    import tbp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int SIZE_BITS   = DEF_SIZE_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  t_cfg_idx       i_cfg_idx,
    input  logic [SIZE_BITS-1:0] i_cfg_data,
    tbp_req_if.sink        i_req,
    tbp_rsp_if.source      o_rsp,
    output logic           o_tbl_we,
    output logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_tbl_waddr,
    output logic [SIZE_BITS:0] o_tbl_wdata,
    output logic [(MAX_ENTRIES>1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_tbl_raddr,
    input  logic [SIZE_BITS:0] i_tbl_rdata,
    output t_alu_sel       o_alu_sel,
    output logic [SIZE_BITS-1:0] o_alu_fast,
    output logic [SIZE_BITS+STAGING_EXTRA-1:0] o_alu_staging,
    output logic [SIZE_BITS-1:0] o_alu_need,
    output logic [SIZE_BITS-1:0] o_alu_budget,
    output logic [SIZE_BITS-1:0] o_alu_limit,
    input  logic [SIZE_BITS+STAGING_EXTRA:0] i_alu_sum,
    input  logic           i_alu_le
);
    localparam int SB  = SIZE_BITS;
    localparam int STB = SIZE_BITS + STAGING_EXTRA;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int AW  = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;

    t_state            r_state, n_state;
    logic [SB-1:0]     r_budget, r_limit;
    logic [CW-1:0]     r_count, n_count;
    logic [SB-1:0]     r_fast, n_fast;
    logic [STB-1:0]    r_staging, n_staging;
    logic              r_out_valid, n_out_valid;

    logic [SB-1:0]     r_need;
    logic              r_prefer;
    logic [SB:0]       r_freed, n_freed;
    logic [CW-1:0]     r_moved, n_moved;
    logic [CW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_pv, n_pv;
    logic [AW-1:0]     r_proc_idx, n_proc_idx;
    t_tier             r_tier, n_tier;
    t_status           r_status, n_status;
    logic              r_store_fast, n_store_fast;
    t_tier             r_out_tier;
    t_status           r_out_status;
    logic [SB-1:0]     r_out_fast;
    logic [STB-1:0]    r_out_staging;
    logic [CW-1:0]     r_out_moved;
    logic              load_out;
    logic              accept;
    logic [SB-1:0]     ent_size;
    logic              ent_fast;

    assign accept   = i_req.valid && i_req.ready;
    assign ent_size = i_tbl_rdata[SB-1:0];
    assign ent_fast = i_tbl_rdata[SB];

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.placed_tier   = r_out_tier;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.fast_used     = r_out_fast;
    assign o_rsp.staging_used  = r_out_staging;
    assign o_rsp.evicted_count = r_out_moved;

    assign o_alu_fast    = r_fast;
    assign o_alu_staging = r_staging;
    assign o_alu_need    = r_need;
    assign o_alu_budget  = r_budget;
    assign o_alu_limit   = r_limit;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_fast       = r_fast;
        n_staging    = r_staging;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_freed      = r_freed;
        n_moved      = r_moved;
        n_rd_idx     = r_rd_idx;
        n_pv         = 1'b0;
        n_proc_idx   = r_proc_idx;
        n_tier       = r_tier;
        n_status     = r_status;
        n_store_fast = r_store_fast;
        load_out     = 1'b0;
        o_alu_sel    = ALU_FAST;
        o_tbl_we     = 1'b0;
        o_tbl_waddr  = r_proc_idx;
        o_tbl_wdata  = {1'b0, ent_size};
        o_tbl_raddr  = r_rd_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                n_moved = '0;
                if (accept) begin
                    n_state = S_FAST_CHK;
                end
            end
            S_FAST_CHK: begin
                o_alu_sel = ALU_FAST;
                if (r_need == '0) begin
                    n_tier   = TIER_SLOW;
                    n_status = ST_OK;
                    n_state  = S_EMIT;
                end else if (r_count == CW'(MAX_ENTRIES)) begin
                    n_tier   = TIER_NONE;
                    n_status = ST_FULL;
                    n_state  = S_EMIT;
                end else if (i_alu_le) begin
                    n_fast       = i_alu_sum[SB-1:0];
                    n_tier       = TIER_FAST;
                    n_status     = ST_OK;
                    n_store_fast = 1'b1;
                    n_state      = S_STORE;
                end else if (r_prefer) begin
                    n_freed  = '0;
                    n_rd_idx = '0;
                    n_state  = S_WALK;
                end else begin
                    n_state = S_STAGE_CHK;
                end
            end
            S_WALK: begin
                // Reads run one entry ahead of the entry being moved.
                if (r_freed >= (SB+1)'(r_need) || (!r_pv && r_rd_idx == r_count)) begin
                    n_state = S_RETRY;
                end else begin
                    if (r_rd_idx < r_count) begin
                        n_rd_idx   = r_rd_idx + 1'b1;
                        n_pv       = 1'b1;
                        n_proc_idx = r_rd_idx[AW-1:0];
                    end
                    if (r_pv && ent_fast) begin
                        o_tbl_we  = 1'b1;
                        n_freed   = r_freed + (SB+1)'(ent_size);
                        n_fast    = (ent_size <= r_fast) ? r_fast - ent_size : '0;
                        n_staging = r_staging + STB'(ent_size);
                        n_moved   = r_moved + 1'b1;
                    end
                end
            end
            S_RETRY: begin
                o_alu_sel = ALU_FAST;
                if (i_alu_le) begin
                    n_fast       = i_alu_sum[SB-1:0];
                    n_tier       = TIER_FAST;
                    n_status     = ST_OK;
                    n_store_fast = 1'b1;
                    n_state      = S_STORE;
                end else begin
                    n_state = S_STAGE_CHK;
                end
            end
            S_STAGE_CHK: begin
                o_alu_sel = ALU_STAGE;
                if (i_alu_le) begin
                    n_staging    = i_alu_sum[STB-1:0];
                    n_tier       = TIER_STAGING;
                    n_status     = ST_OK;
                    n_store_fast = 1'b0;
                    n_state      = S_STORE;
                end else begin
                    n_tier   = TIER_NONE;
                    n_status = ST_OVER;
                    n_state  = S_EMIT;
                end
            end
            S_STORE: begin
                o_tbl_we    = 1'b1;
                o_tbl_waddr = r_count[AW-1:0];
                o_tbl_wdata = {r_store_fast, r_need};
                n_count     = r_count + 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_budget    <= '0;
            r_limit     <= '0;
            r_count     <= '0;
            r_fast      <= '0;
            r_staging   <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_fast      <= n_fast;
            r_staging   <= n_staging;
            r_out_valid <= n_out_valid;
            r_pv        <= n_pv;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FAST_BUDGET:   r_budget <= i_cfg_data;
                    CFG_STAGING_LIMIT: r_limit  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_need   <= i_req.shard_size;
            r_prefer <= i_req.prefer_fast;
        end
        r_freed      <= n_freed;
        r_moved      <= n_moved;
        r_rd_idx     <= n_rd_idx;
        r_proc_idx   <= n_proc_idx;
        r_tier       <= n_tier;
        r_status     <= n_status;
        r_store_fast <= n_store_fast;
        if (load_out) begin
            r_out_tier    <= r_tier;
            r_out_status  <= r_status;
            r_out_fast    <= r_fast;
            r_out_staging <= r_staging;
            r_out_moved   <= r_moved;
        end
    end
endmodule

/* hdl/tiered_budget_placement.sv */
// ----------------------------------------------------------------------------
// Tiered budget placement
// Places shards into a fast or a staging tier under byte budgets, moving
// older fast entries to staging on demand.
// ----------------------------------------------------------------------------
// The request channel carries a shard size and a prefer-fast flag; the
// result channel returns one word per request: the tier, a status, the fast
// and staging bytes in use afterwards and the number of entries moved.
// The two byte limits are loaded through the write port (index 0 is the fast
// budget, index 1 the staging limit). The user must load them only while
// no request is in flight; the block itself does not enforce this.
// A request is taken only while the sequencer is idle. An empty shard or a
// full table goes from the fast check straight to emit; a direct fast fit
// goes through store, an over budget result through the staging check and a
// staging placement through the staging check and store. With prefer-fast
// set and no direct fit, the table is walked oldest first through its
// single registered read port, one entry per cycle, before a fast retry.
// A new request is taken only after the last one has passed emit.
// Reset clears the limits, the usage totals, the entry count and the result
// valid flag; the table contents need no clearing because only entries below
// the count are ever used. A result word waits in its output register while
// the receiver stalls, and the next request is still taken meanwhile; the
// sequencer holds before publishing the following result until then.
// ----------------------------------------------------------------------------
module tiered_budget_placement
    import tbp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int SIZE_BITS   = DEF_SIZE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  t_cfg_idx             i_cfg_idx,
    input  logic [SIZE_BITS-1:0] i_cfg_data,
    tbp_req_if.sink              i_req,
    tbp_rsp_if.source            o_rsp
);
    localparam int STB = SIZE_BITS + STAGING_EXTRA;
    localparam int AW  = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;

    // Table port between the sequencer and the entry memory.
    logic                 tbl_we;
    logic [AW-1:0]        tbl_waddr;
    logic [SIZE_BITS:0]   tbl_wdata;
    logic [AW-1:0]        tbl_raddr;
    logic [SIZE_BITS:0]   tbl_rdata;

    // Operands and result of the shared add-and-compare unit.
    t_alu_sel             alu_sel;
    logic [SIZE_BITS-1:0] alu_fast;
    logic [STB-1:0]       alu_staging;
    logic [SIZE_BITS-1:0] alu_need;
    logic [SIZE_BITS-1:0] alu_budget;
    logic [SIZE_BITS-1:0] alu_limit;
    logic [STB:0]         alu_sum;
    logic                 alu_le;

    tbp_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SIZE_BITS   (SIZE_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_tbl_we      (tbl_we),
        .o_tbl_waddr   (tbl_waddr),
        .o_tbl_wdata   (tbl_wdata),
        .o_tbl_raddr   (tbl_raddr),
        .i_tbl_rdata   (tbl_rdata),
        .o_alu_sel     (alu_sel),
        .o_alu_fast    (alu_fast),
        .o_alu_staging (alu_staging),
        .o_alu_need    (alu_need),
        .o_alu_budget  (alu_budget),
        .o_alu_limit   (alu_limit),
        .i_alu_sum     (alu_sum),
        .i_alu_le      (alu_le)
    );

    tbp_table #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SIZE_BITS   (SIZE_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    tbp_addcmp #(
        .SIZE_BITS (SIZE_BITS)
    ) u_addcmp (
        .i_sel     (alu_sel),
        .i_fast    (alu_fast),
        .i_staging (alu_staging),
        .i_need    (alu_need),
        .i_budget  (alu_budget),
        .i_limit   (alu_limit),
        .o_sum     (alu_sum),
        .o_le      (alu_le)
    );
endmodule

/* hdl/tbp_checker.sv */
// ----------------------------------------------------------------------------
// Placement block checker
// Port-level assertions on the placement block, attached by bind.
// ----------------------------------------------------------------------------
`include "tiered_budget_placement_defines.svh"

module tbp_checker
    import tbp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int SIZE_BITS   = DEF_SIZE_BITS
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_req_valid,
    input logic                               i_req_ready,
    input logic                               i_rsp_valid,
    input logic                               i_rsp_ready,
    input t_tier                              i_placed_tier,
    input t_status                            i_status,
    input logic [SIZE_BITS-1:0]               i_fast_used,
    input logic [SIZE_BITS+STAGING_EXTRA-1:0] i_staging_used,
    input logic [$clog2(MAX_ENTRIES+1)-1:0]   i_evicted_count
);
    // No result word survives reset.
    `TBP_ASSERT_RST(a_rst_clear, !i_rst_n |=> !i_rsp_valid, "result valid after reset")

    // A stalled result word stays valid and holds its usage and moved-count fields.
    `TBP_ASSERT(a_rsp_hold, (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_fast_used) && $stable(i_staging_used) && $stable(i_evicted_count)), "stalled result changed")

    // One request at a time: ready drops right after acceptance.
    `TBP_ASSERT(a_one_item, (i_req_valid && i_req_ready) |=> !i_req_ready, "request taken while busy")

    // A full table or an empty shard moves nothing and reports consistently.
    `TBP_ASSERT(a_full_code, i_rsp_valid |-> ((i_status != ST_FULL) || ((i_placed_tier == TIER_NONE) && (i_evicted_count == '0))), "bad table-full result")

    `TBP_ASSERT(a_slow_code, i_rsp_valid |-> ((i_placed_tier != TIER_SLOW) || ((i_status == ST_OK) && (i_evicted_count == '0))), "bad empty-shard result")
endmodule

bind tiered_budget_placement tbp_checker #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SIZE_BITS   (SIZE_BITS)
) u_tbp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_placed_tier   (o_rsp.placed_tier),
    .i_status        (o_rsp.status),
    .i_fast_used     (o_rsp.fast_used),
    .i_staging_used  (o_rsp.staging_used),
    .i_evicted_count (o_rsp.evicted_count)
);

/* bench/tb_tiered_budget_placement.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tiered budget placement testbench
// Drives shard requests through the request channel, predicts each result
// word from an internal copy of the placement table and compares every field.
// ----------------------------------------------------------------------------
// The run starts with a short table of directed rows: empty shards, the size
// extremes, direct fits, walks that move fast entries to staging, and over
// budget cases. Rows whose result is obvious carry the expected word typed in;
// all others are checked against the predictor. Random phases follow, each
// with its own pair of byte limits and an idling pattern. The table is
// never cleared, so it fills over the run and the full-table status is
// reached in the later phases.
// ----------------------------------------------------------------------------
module tb_tiered_budget_placement;
    import tbp_pkg::*;

    localparam int SZ          = DEF_SIZE_BITS;
    localparam int STB         = SZ + STAGING_EXTRA;
    localparam int MAX_ENTRIES = DEF_MAX_ENTRIES;
    localparam int EW          = $clog2(MAX_ENTRIES + 1);
    localparam logic [63:0] SIZE_MAX  = (64'd1 << SZ) - 64'd1;
    localparam logic [63:0] STG_MASK  = (64'd1 << STB) - 64'd1;
    // Cycles without any handshake or register write before the run is
    // declared hung. A request that walks the whole table, with the receiver
    // stall on top of that, stays far below this.
    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 196;

    // One result word as the block returns it.
    typedef struct packed {
        t_tier              tier;
        t_status            status;
        logic [SZ-1:0]      fast_used;
        logic [STB-1:0]     staging_used;
        logic [EW-1:0]      evicted;
    } t_placement;

    typedef enum {
        ROW_REQ,
        ROW_LIMITS
    } t_row_kind;

    // One row of the directed table: either a request word or a new pair
    // of byte limits. A request row may carry its expected word.
    typedef struct {
        t_row_kind      kind;
        logic [SZ-1:0]  size;
        logic           prefer;
        bit             checked;
        t_placement     want;
        logic [63:0]    fast;
        logic [63:0]    stage;
    } t_stim_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    t_cfg_idx        i_cfg_idx;
    logic [SZ-1:0]   i_cfg_data;

    tbp_req_if req_if ();
    tbp_rsp_if rsp_if ();

    tiered_budget_placement dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // Predictor state: the stored table, the usage totals and the limits.
    // Totals are kept at 64 bits so that the budget comparisons never wrap.
    logic [SZ-1:0]  shard_sz   [MAX_ENTRIES];
    logic           shard_fast [MAX_ENTRIES];
    int             shard_cnt;
    logic [63:0]    fast_total;
    logic [63:0]    staging_total;
    logic [63:0]    budget_fast;
    logic [63:0]    limit_stage;

    t_placement     pending_results [$];
    t_stim_row      directed_rows [$];
    t_placement     no_typed_word;

    int             mismatches;
    int             quiet_cycles;
    int             send_idle_pct;
    int             recv_idle_pct;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = ~i_clk;
    end

    // Works out the result word of one accepted request and updates the
    // predictor state the way the block updates its own.
    function automatic t_placement place_shard(input logic [SZ-1:0] need, input logic prefer);
        t_placement  r;
        logic [63:0] freed;
        int          moved;
        bit          placed;

        moved    = 0;
        placed   = 1'b0;
        r.tier   = TIER_NONE;
        r.status = ST_OVER;
        if (need == '0) begin
            // An empty shard goes to the slow tier and is never stored,
            // not even when the table is full.
            r.tier   = TIER_SLOW;
            r.status = ST_OK;
        end else if (shard_cnt >= MAX_ENTRIES) begin
            r.status = ST_FULL;
        end else begin
            if (fast_total + need <= budget_fast) begin
                r.tier = TIER_FAST;
                placed = 1'b1;
            end else if (prefer) begin
                // Oldest first: move fast entries to staging until the bytes
                // freed cover the request, then try the fast tier again.
                freed = '0;
                for (int i = 0; i < shard_cnt && freed < need; i++) begin
                    if (shard_fast[i]) begin
                        freed         = freed + shard_sz[i];
                        shard_fast[i] = 1'b0;
                        fast_total    = (shard_sz[i] <= fast_total) ?
                                        fast_total - shard_sz[i] : '0;
                        staging_total = (staging_total + shard_sz[i]) & STG_MASK;
                        moved++;
                    end
                end
                if (fast_total + need <= budget_fast) begin
                    r.tier = TIER_FAST;
                    placed = 1'b1;
                end
            end
            if (!placed && staging_total + need <= limit_stage) begin
                r.tier = TIER_STAGING;
                placed = 1'b1;
            end
            if (placed) begin
                r.status = ST_OK;
                if (r.tier == TIER_FAST) begin
                    fast_total = fast_total + need;
                end else begin
                    staging_total = (staging_total + need) & STG_MASK;
                end
                shard_sz[shard_cnt]   = need;
                shard_fast[shard_cnt] = (r.tier == TIER_FAST);
                shard_cnt++;
            end
        end
        r.fast_used    = fast_total[SZ-1:0];
        r.staging_used = staging_total[STB-1:0];
        r.evicted      = moved[EW-1:0];
        return r;
    endfunction

    // Uniform-ish pick in [lo, hi]; both bounds stay within the size range.
    function automatic logic [63:0] pick_between(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return lo + (r % (hi - lo + 64'd1));
    endfunction

    // A size with every bit random, shifted down by a random amount so that
    // small and large magnitudes both turn up.
    function automatic logic [SZ-1:0] noise_size();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[SZ-1:0] >> $urandom_range(SZ - 1, 0);
    endfunction

    task automatic add_req(input logic [SZ-1:0] size, input logic prefer);
        t_stim_row row;
        row.kind    = ROW_REQ;
        row.size    = size;
        row.prefer  = prefer;
        row.checked = 1'b0;
        row.want    = no_typed_word;
        row.fast    = '0;
        row.stage   = '0;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_checked_req(input logic [SZ-1:0] size, input logic prefer,
                                   input t_tier tier, input t_status status,
                                   input logic [63:0] fast_used,
                                   input logic [63:0] staging_used, input int evicted);
        t_stim_row row;
        row.kind               = ROW_REQ;
        row.size               = size;
        row.prefer             = prefer;
        row.checked            = 1'b1;
        row.want.tier          = tier;
        row.want.status        = status;
        row.want.fast_used     = fast_used[SZ-1:0];
        row.want.staging_used  = staging_used[STB-1:0];
        row.want.evicted       = evicted[EW-1:0];
        row.fast               = '0;
        row.stage              = '0;
        directed_rows = {directed_rows, row};
    endtask

    task automatic add_limits(input logic [63:0] fast, input logic [63:0] stage);
        t_stim_row row;
        row.kind    = ROW_LIMITS;
        row.size    = '0;
        row.prefer  = 1'b0;
        row.checked = 1'b0;
        row.want    = no_typed_word;
        row.fast    = fast;
        row.stage   = stage;
        directed_rows = {directed_rows, row};
    endtask

    // Presents one request word and holds it until the block takes it. The
    // caller sits at a rising edge; the task returns at the edge of
    // acceptance, without touching valid in that step.
    task automatic send_item(input logic [SZ-1:0] size, input logic prefer,
                             input bit checked, input t_placement typed_word);
        t_placement predicted;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.shard_size  <= size;
        req_if.prefer_fast <= prefer;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        // The predictor always runs so that its state follows the block,
        // even when the row brings its own expected word.
        predicted = place_shard(size, prefer);
        pending_results = {pending_results, (checked ? typed_word : predicted)};
    endtask

    // Loads both byte limits once every outstanding result word is back, so
    // the block is idle while its registers change.
    task automatic load_limits(input logic [63:0] fast, input logic [63:0] stage);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FAST_BUDGET;
        i_cfg_data <= fast[SZ-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STAGING_LIMIT;
        i_cfg_data <= stage[SZ-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        budget_fast = fast & SIZE_MAX;
        limit_stage = stage & SIZE_MAX;
    endtask

    // Picks one random request word from the current predictor state. Most
    // words are sized to miss both limits, so that walks and over budget
    // results keep coming without filling the table too early.
    task automatic send_random_item();
        logic [63:0]   hi;
        logic [63:0]   lo;
        logic [SZ-1:0] size;
        logic          prefer;
        int            pick;

        pick   = $urandom_range(99, 0);
        prefer = ($urandom_range(9, 0) < 7);
        if (pick < 8) begin
            size = '0;
        end else if (pick < 18) begin
            // Something that should fit, sized well under the active limit.
            if (budget_fast >= 64'd3) begin
                hi = budget_fast / 3;
            end else begin
                hi = (limit_stage >= 64'd8) ? limit_stage / 8 : 64'd1;
            end
            size = SZ'(pick_between(64'd1, hi));
        end else if (pick < 26) begin
            size = noise_size();
        end else begin
            // Larger than the fast budget and than the staging room left.
            lo = (limit_stage > staging_total) ? limit_stage - staging_total : 64'd0;
            if (budget_fast > lo) begin
                lo = budget_fast;
            end
            lo = lo + 64'd1;
            size = (lo <= SIZE_MAX) ? SZ'(pick_between(lo, SIZE_MAX)) : noise_size();
        end
        send_item(size, prefer, 1'b0, no_typed_word);
    endtask

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Checks every result word taken from the block against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("result word arrived with no request outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.placed_tier !== want.tier) begin
                    $error("placed_tier: expected %0d, got %0d", want.tier,
                           rsp_if.placed_tier);
                    mismatches++;
                end
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    mismatches++;
                end
                if (rsp_if.fast_used !== want.fast_used) begin
                    $error("fast_used: expected %0d, got %0d", want.fast_used,
                           rsp_if.fast_used);
                    mismatches++;
                end
                if (rsp_if.staging_used !== want.staging_used) begin
                    $error("staging_used: expected %0d, got %0d", want.staging_used,
                           rsp_if.staging_used);
                    mismatches++;
                end
                if (rsp_if.evicted_count !== want.evicted) begin
                    $error("evicted_count: expected %0d, got %0d", want.evicted,
                           rsp_if.evicted_count);
                    mismatches++;
                end
            end
        end
    end

    // Hang detection: any handshake or register write restarts the count.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tiered_budget_placement verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [63:0] fast;
        logic [63:0] stage;

        // Known values on every input before the first edge.
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_FAST_BUDGET;
        i_cfg_data         = '0;
        req_if.valid       = 1'b0;
        req_if.shard_size  = '0;
        req_if.prefer_fast = 1'b0;
        rsp_if.ready       = 1'b0;
        mismatches         = 0;
        quiet_cycles       = 0;
        send_idle_pct      = 20;
        recv_idle_pct      = 63;
        no_typed_word      = '0;

        shard_cnt     = 0;
        fast_total    = '0;
        staging_total = '0;
        budget_fast   = '0;
        limit_stage   = '0;

        // Both limits are zero after reset: nothing but an empty shard can
        // be placed, and every other shard comes back over budget.
        add_checked_req('0, 1'b0, TIER_SLOW, ST_OK, 0, 0, 0);
        add_checked_req('0, 1'b1, TIER_SLOW, ST_OK, 0, 0, 0);
        add_checked_req(1, 1'b1, TIER_NONE, ST_OVER, 0, 0, 0);
        add_checked_req(SIZE_MAX[SZ-1:0], 1'b0, TIER_NONE, ST_OVER, 0, 0, 0);
        // A fast budget of 1000 bytes with the widest staging limit. The
        // first shard fills the fast tier exactly, the next spills over.
        add_limits(64'd1000, SIZE_MAX);
        add_checked_req(1000, 1'b0, TIER_FAST, ST_OK, 1000, 0, 0);
        add_checked_req(1, 1'b0, TIER_STAGING, ST_OK, 1000, 1, 0);
        // Walks: one entry moved, a direct fit, then two entries moved.
        add_req(400, 1'b1);
        add_req(300, 1'b1);
        add_req(500, 1'b1);
        // The largest shard still moves entries, but then fits nowhere.
        add_req(SIZE_MAX[SZ-1:0], 1'b1);
        add_req(SIZE_MAX[SZ-1:0], 1'b0);
        // Widest fast budget, no staging room at all.
        add_limits(SIZE_MAX, 64'd0);
        add_req(SIZE_MAX[SZ-1:0], 1'b0);
        add_req(1, 1'b0);
        add_req(1, 1'b1);
        // Both limits at zero: walks free bytes but nothing can be placed.
        add_limits(64'd0, 64'd0);
        add_req(40'h55_5555_5555, 1'b1);
        add_req(40'hAA_AAAA_AAAA, 1'b0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_LIMITS) begin
                load_limits(directed_rows[n].fast, directed_rows[n].stage);
            end else begin
                send_item(directed_rows[n].size, directed_rows[n].prefer,
                          directed_rows[n].checked, directed_rows[n].want);
            end
        end

        // Random phases. The widest limits come last, since they let nearly
        // every shard be stored and the table then fills quickly.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    fast  = pick_between(64'd1 << 12, 64'd1 << 20);
                    stage = fast * 4 + pick_between(64'd0, 64'd1 << 16);
                end
                1: begin
                    fast  = pick_between(64'd1, 64'd1 << 16);
                    stage = 64'd0;
                end
                2: begin
                    fast  = 64'd0;
                    stage = pick_between(64'd1 << 10, 64'd1 << 24);
                end
                default: begin
                    fast  = SIZE_MAX;
                    stage = SIZE_MAX;
                end
            endcase
            load_limits(fast, stage);
            // Idling pattern: the receiver lags first, then the sender,
            // then both sides run flat out.
            case (phase)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                send_random_item();
            end
        end

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        // Give a stray extra result word time to show up.
        repeat (MAX_ENTRIES + 16) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("tiered_budget_placement verification clean");
        end else begin
            $display("tiered_budget_placement verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tbp_pkg.sv
hdl/tbp_req_if.sv
hdl/tbp_rsp_if.sv
hdl/tbp_addcmp.sv
hdl/tbp_table.sv
hdl/tbp_seq.sv
hdl/tiered_budget_placement.sv
hdl/tbp_checker.sv
bench/tb_tiered_budget_placement.sv
